@@ hw/rtl/ctdh_pkg.sv @@
// ----------------------------------------------------------------------------
// ctdh_pkg
// Types, codes and constants shared by the coincidence histogram block.
// ----------------------------------------------------------------------------
package ctdh_pkg;

    localparam int HIST_BINS_DEF     = 32768;
    localparam int PENDING_DEPTH_DEF = 16;

    localparam int TIME_BITS  = 48;
    localparam int CHAN_W     = 12;
    localparam int BIN_IDX_W  = 15;
    localparam int COUNT_W    = 32;
    localparam int FILLS_W    = 5;
    localparam int WINDOW_W   = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_CHANNEL = 2'd0,
        CFG_STOP_CHANNEL  = 2'd1,
        CFG_WINDOW_NS     = 2'd2
    } cfg_index_t;

    typedef enum logic {
        FUNC_HIT  = 1'b0,
        FUNC_READ = 1'b1
    } func_t;

    typedef struct packed {
        func_t                func;
        logic [CHAN_W-1:0]    hit_channel;
        logic [TIME_BITS-1:0] hit_time;
        logic [BIN_IDX_W-1:0] bin_index;
    } item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] bin_count;
        logic [FILLS_W-1:0] fills;
        logic               overflow;
    } result_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_BUMP,
        ST_READ,
        ST_POST
    } ctrl_state_t;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic rd_bin;
        logic rd_dt;
        logic retire;
        logic bump;
        logic advance;
        logic finish;
    } ctdh_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic new_is_read;
        logic k_valid;
        logic dt_over;
        logic dt_hit;
        logic k_last;
        logic out_free;
        logic item_taken;
    } ctdh_status_t;

endpackage

@@ hw/rtl/coincidence_time_difference_histogram.sv @@
// ----------------------------------------------------------------------------
// coincidence_time_difference_histogram
// Start/stop coincidence timing histogram with a ring of pending start hits.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the histogram, one bin a
// cycle, and takes no item until it ends; configuration writes are taken at
// any time. Items are handled one at a time. A read item passes through the
// READ and POST states from accept to result load. A hit item scans the
// whole ring, one entry a cycle, with a BUMP state added for every pending
// entry it pairs with into an in-range bin, since each bin update is a
// read-modify-write on the histogram memory's single port; POST then holds
// while the result register is full. The result register lets the next item
// be accepted while a result beat is still waiting.
// ----------------------------------------------------------------------------
module coincidence_time_difference_histogram #(
    parameter int HIST_BINS     = ctdh_pkg::HIST_BINS_DEF,
    parameter int PENDING_DEPTH = ctdh_pkg::PENDING_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  ctdh_pkg::item_t                 item,
    output logic                            result_valid,
    input  logic                            result_ready,
    output ctdh_pkg::result_t               result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ctdh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ctdh_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ctdh_pkg::*;

    ctdh_cmd_t    cmd;
    ctdh_status_t status;

    assign cfg_ready = 1'b1;

    ctdh_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .status     (status),
        .cmd        (cmd),
        .item_ready (item_ready)
    );

    ctdh_datapath #(
        .HIST_BINS     (HIST_BINS),
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .item_valid   (item_valid),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

endmodule

@@ hw/rtl/ctdh_ctrl.sv @@
// ----------------------------------------------------------------------------
// ctdh_ctrl
// Sequencer: clearing pass, ring scan, bin read-modify-write and result load.
// ----------------------------------------------------------------------------
module ctdh_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctdh_pkg::ctdh_status_t status,
    output ctdh_pkg::ctdh_cmd_t    cmd,
    output logic                  item_ready
);
    import ctdh_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                item_ready = 1'b1;
                cmd.load   = 1'b1;
                // leave only when a beat is really taken
                if (status.item_taken)
                begin
                    if (status.new_is_read)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (status.k_valid && !status.dt_over && status.dt_hit)
                begin
                    // fetch the bin, update it next cycle
                    cmd.rd_dt  = 1'b1;
                    state_next = ST_BUMP;
                end
                else
                begin
                    cmd.retire  = status.k_valid && status.dt_over;
                    cmd.advance = 1'b1;
                    if (status.k_last)
                    begin
                        state_next = ST_POST;
                    end
                end
            end
            ST_BUMP:
            begin
                cmd.bump    = 1'b1;
                cmd.advance = 1'b1;
                state_next  = status.k_last ? ST_POST : ST_SCAN;
            end
            ST_READ:
            begin
                cmd.rd_bin = 1'b1;
                state_next = ST_POST;
            end
            ST_POST:
            begin
                // hold until the result register can take the beat
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

@@ hw/rtl/ctdh_datapath.sv @@
// ----------------------------------------------------------------------------
// ctdh_datapath
// Configuration, pending ring, histogram memory and result register.
// ----------------------------------------------------------------------------
module ctdh_datapath #(
    parameter int HIST_BINS     = ctdh_pkg::HIST_BINS_DEF,
    parameter int PENDING_DEPTH = ctdh_pkg::PENDING_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ctdh_pkg::ctdh_cmd_t               cmd,
    output ctdh_pkg::ctdh_status_t            status,
    input  logic                              item_valid,
    input  ctdh_pkg::item_t                   item,
    output logic                              result_valid,
    input  logic                              result_ready,
    output ctdh_pkg::result_t                 result,
    input  logic                              cfg_valid,
    input  logic [ctdh_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ctdh_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import ctdh_pkg::*;

    localparam int BW = $clog2(HIST_BINS);
    localparam int PW = $clog2(PENDING_DEPTH);

    logic [CHAN_W-1:0]    start_ch_reg;
    logic [CHAN_W-1:0]    stop_ch_reg;
    logic [WINDOW_W-1:0]  window_reg;

    item_t                item_reg;
    logic [PW-1:0]        k_reg;
    logic [PW-1:0]        head_reg;
    logic [PENDING_DEPTH-1:0] pv_reg;
    logic [TIME_BITS-1:0] pt_mem [PENDING_DEPTH];
    logic [BW-1:0]        dt_reg;
    logic [FILLS_W-1:0]   fills_reg;
    logic                 ovf_reg;
    logic                 ovf_next;
    logic [BW-1:0]        clr_reg;
    logic [COUNT_W-1:0]   rd_reg;
    logic [COUNT_W-1:0]   hist_mem [HIST_BINS];
    result_t              res_reg;
    result_t              res_next;
    logic                 res_valid_reg;

    logic [TIME_BITS-1:0] dt;
    logic [31:0]          idx_ext;
    logic                 idx_in_range;
    logic                 k_last;
    logic                 sat;
    logic                 insert;
    logic                 mem_we;
    logic                 mem_re;
    logic [BW-1:0]        mem_wa;
    logic [BW-1:0]        mem_ra;
    logic [COUNT_W-1:0]   mem_wd;
    logic                 take;

    // dt wraps at the timestamp width
    assign dt           = item_reg.hit_time - pt_mem[k_reg];
    assign idx_ext      = 32'(item_reg.bin_index);
    assign idx_in_range = idx_ext < 32'(HIST_BINS);
    assign k_last       = k_reg == PW'(PENDING_DEPTH - 1);
    assign sat          = rd_reg == '1;
    assign insert       = cmd.finish && item_reg.func == FUNC_HIT
                          && item_reg.hit_channel == start_ch_reg;
    assign ovf_next     = ovf_reg | (insert & pv_reg[head_reg]);
    assign take         = cmd.load & item_valid;

    always_comb
    begin
        status.clr_done    = clr_reg == BW'(HIST_BINS - 1);
        status.new_is_read = item_valid && item.func == FUNC_READ;
        status.k_valid     = pv_reg[k_reg];
        status.dt_over     = dt > TIME_BITS'(window_reg);
        status.dt_hit      = item_reg.hit_channel == stop_ch_reg
                             && dt < TIME_BITS'(HIST_BINS);
        status.k_last      = k_last;
        status.out_free    = !res_valid_reg || result_ready;
        status.item_taken  = take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_ch_reg <= '0;
            stop_ch_reg  <= '0;
            window_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_START_CHANNEL: start_ch_reg <= cfg_data[CHAN_W-1:0];
                CFG_STOP_CHANNEL:  stop_ch_reg  <= cfg_data[CHAN_W-1:0];
                CFG_WINDOW_NS:     window_reg   <= cfg_data[WINDOW_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item;
        end
        if (cmd.rd_dt)
        begin
            dt_reg <= dt[BW-1:0];
        end
        if (insert)
        begin
            pt_mem[head_reg] <= item_reg.hit_time;
        end
        if (cmd.finish)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            head_reg      <= '0;
            pv_reg        <= '0;
            fills_reg     <= '0;
            ovf_reg       <= 1'b0;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                k_reg     <= '0;
                fills_reg <= '0;
            end
            else if (cmd.advance)
            begin
                k_reg <= k_last ? '0 : k_reg + 1'b1;
            end
            if (cmd.bump && !sat && fills_reg != '1)
            begin
                fills_reg <= fills_reg + 1'b1;
            end
            if (cmd.retire)
            begin
                pv_reg[k_reg] <= 1'b0;
            end
            if (insert)
            begin
                pv_reg[head_reg] <= 1'b1;
                head_reg <= (head_reg == PW'(PENDING_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            end
            ovf_reg <= ovf_next;
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            res_valid_reg <= cmd.finish | (res_valid_reg & ~result_ready);
        end
    end

    // single-port style histogram: one write and one registered read a cycle
    always_comb
    begin
        mem_we = cmd.clr_step | (cmd.bump & ~sat);
        mem_wa = cmd.clr_step ? clr_reg : dt_reg;
        mem_wd = cmd.clr_step ? '0 : rd_reg + 1'b1;
        mem_re = cmd.rd_dt | (cmd.rd_bin & idx_in_range);
        mem_ra = cmd.rd_dt ? dt[BW-1:0] : idx_ext[BW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist_mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_reg <= hist_mem[mem_ra];
        end
    end

    always_comb
    begin
        if (item_reg.func == FUNC_READ)
        begin
            res_next.bin_count = idx_in_range ? rd_reg : '0;
            res_next.fills     = '0;
        end
        else
        begin
            res_next.bin_count = '0;
            res_next.fills     = fills_reg;
        end
        res_next.overflow = ovf_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

@@ hw/rtl/ctdh_checker.sv @@
// ----------------------------------------------------------------------------
// ctdh_checker
// Port-level checks on the coincidence histogram, bound to the top level.
// ----------------------------------------------------------------------------
module ctdh_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_ready,
    input logic              result_valid,
    input logic              result_ready,
    input ctdh_pkg::result_t result
);
    import ctdh_pkg::*;

    // a stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

    // one item at a time: ready drops right after an accepted beat
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
    else $error("item accepted while another is in flight");

    // a result carries either a bin count or a fill count, never both
    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.bin_count == '0 || result.fills == '0)
    else $error("result carries both bin count and fills");

endmodule

bind coincidence_time_difference_histogram ctdh_checker u_ctdh_checker (.*);

@@ dv/coincidence_time_difference_histogram_tb.sv @@
// ----------------------------------------------------------------------------
// coincidence_time_difference_histogram_tb
// Drives hit and read beats into the coincidence histogram block and checks
// every result beat against a typed expectation or a cycle-free prediction
// of the pending ring and the histogram. A short directed table covers the
// extremes, then several settings each get random, mostly time-ordered hits.
// ----------------------------------------------------------------------------
module coincidence_time_difference_histogram_tb;

    import ctdh_pkg::*;

    localparam int HIST_BINS       = HIST_BINS_DEF;
    localparam int RING_DEPTH      = PENDING_DEPTH_DEF;
    localparam int STALL_LONG      = 400;
    localparam int WATCHDOG_LIMIT  = 100000;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int RECENT_MAX      = 32;

    // index past the end of the register list
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_CHOKED
    } rx_mode_t;

    typedef struct {
        row_kind_t                kind;
        item_t                    beat;
        logic [CFG_IDX_W-1:0]     reg_idx;
        logic [CFG_DATA_W-1:0]    reg_data;
        bit                       typed;
        result_t                  want;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  item_valid;
    logic                  item_ready;
    item_t                 item;
    logic                  result_valid;
    logic                  result_ready;
    result_t               result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    coincidence_time_difference_histogram dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predicted block state
    logic [CHAN_W-1:0]    start_chan_m;
    logic [CHAN_W-1:0]    stop_chan_m;
    logic [WINDOW_W-1:0]  window_m;
    logic [TIME_BITS-1:0] pend_time_m [RING_DEPTH];
    bit                   pend_valid_m [RING_DEPTH];
    int unsigned          ring_head_m;
    int unsigned          hist_m [HIST_BINS];
    bit                   overflow_m;

    result_t              results_due [$];
    logic [BIN_IDX_W-1:0] recent_dt [$];
    logic [TIME_BITS-1:0] cur_time;

    int fail_count     = 0;
    int hits_sent      = 0;
    int reads_sent     = 0;
    int settings_made  = 0;
    int overflow_beats = 0;
    int busy_reads     = 0;
    int burst_left     = 0;
    int stall_asked    = 0;
    int stall_done     = 0;
    int quiet_cycles   = 0;
    result_t exp_beat;

    function automatic result_t predict_bins(input item_t b);
        result_t              r;
        logic [TIME_BITS-1:0] dt;
        int unsigned          n;
        int                   k;
        r = '0;
        n = 0;
        if (b.func == FUNC_READ)
        begin
            r.bin_count = (int'(b.bin_index) < HIST_BINS) ? hist_m[b.bin_index] : '0;
            r.overflow  = overflow_m;
            return r;
        end
        for (k = 0; k < RING_DEPTH; k++)
        begin
            if (!pend_valid_m[k])
                continue;
            dt = b.hit_time - pend_time_m[k];
            // retire entries that fell out of the window, wrapped ones too
            if (dt > window_m)
            begin
                pend_valid_m[k] = 1'b0;
                continue;
            end
            if (b.hit_channel == stop_chan_m && dt < HIST_BINS)
            begin
                if (hist_m[dt[BIN_IDX_W-1:0]] != 32'hFFFF_FFFF)
                begin
                    hist_m[dt[BIN_IDX_W-1:0]]++;
                    n++;
                end
                recent_dt.push_back(dt[BIN_IDX_W-1:0]);
                if (recent_dt.size() > RECENT_MAX)
                    void'(recent_dt.pop_front());
            end
        end
        // compare first, then open a window, so a hit never pairs with itself
        if (b.hit_channel == start_chan_m)
        begin
            if (pend_valid_m[ring_head_m])
                overflow_m = 1'b1;
            pend_time_m[ring_head_m]  = b.hit_time;
            pend_valid_m[ring_head_m] = 1'b1;
            ring_head_m = (ring_head_m + 1) % RING_DEPTH;
        end
        r.fills    = (n > 31) ? FILLS_W'(31) : FILLS_W'(n);
        r.overflow = overflow_m;
        return r;
    endfunction

    function automatic stim_row_t item_row(input func_t f, input int unsigned ch,
                                           input logic [TIME_BITS-1:0] t,
                                           input int unsigned idx, input bit typed,
                                           input logic [COUNT_W-1:0] count,
                                           input int unsigned fills, input logic ovf);
        stim_row_t r;
        r.kind             = ROW_ITEM;
        r.beat.func        = f;
        r.beat.hit_channel = CHAN_W'(ch);
        r.beat.hit_time    = t;
        r.beat.bin_index   = BIN_IDX_W'(idx);
        r.reg_idx          = '0;
        r.reg_data         = '0;
        r.typed            = typed;
        r.want.bin_count   = count;
        r.want.fills       = FILLS_W'(fills);
        r.want.overflow    = ovf;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        stim_row_t r;
        r.kind     = ROW_CFG;
        r.beat     = '0;
        r.reg_idx  = idx;
        r.reg_data = data;
        r.typed    = 1'b0;
        r.want     = '0;
        return r;
    endfunction

    function automatic item_t random_beat();
        item_t       b;
        int unsigned span;
        int unsigned r;
        b.func        = FUNC_HIT;
        b.hit_channel = CHAN_W'($urandom);
        b.hit_time    = TIME_BITS'({$urandom, $urandom});
        b.bin_index   = BIN_IDX_W'($urandom);
        span = (window_m < 4000) ? window_m / 4 + 2 : 2000;
        if ($urandom_range(0, 99) < 15)
        begin
            b.func = FUNC_READ;
            // aim most reads at bins that have been filled
            if (recent_dt.size() != 0 && $urandom_range(0, 9) < 7)
                b.bin_index = recent_dt[$urandom_range(0, recent_dt.size() - 1)];
            return b;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
            cur_time = TIME_BITS'({$urandom, $urandom});
        else if (r < 9)
            cur_time = cur_time - $urandom_range(0, span);
        else
            cur_time = cur_time + $urandom_range(0, span);
        b.hit_time = cur_time;
        r = $urandom_range(0, 9);
        if (r < 4)
            b.hit_channel = start_chan_m;
        else if (r < 8)
            b.hit_channel = stop_chan_m;
        return b;
    endfunction

    task automatic send_beat(input item_t b, input bit typed, input result_t want);
        int      gap;
        result_t pred;
        gap = 0;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        @(negedge clk);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= b;
        do @(posedge clk); while (!item_ready);
        pred = predict_bins(b);
        results_due.push_back(typed ? want : pred);
        if (b.func == FUNC_READ)
            reads_sent++;
        else
            hits_sent++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        item_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_START_CHANNEL: start_chan_m = data[CHAN_W-1:0];
            CFG_STOP_CHANNEL:  stop_chan_m  = data[CHAN_W-1:0];
            CFG_WINDOW_NS:     window_m     = data[WINDOW_W-1:0];
            default:           ;
        endcase
        settings_made++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Receiver: change pattern now and then, serve long hold-off requests
    initial
    begin : receiver
        rx_mode_t mode;
        int       mode_left;
        result_ready = 1'b0;
        mode         = RX_OPEN;
        mode_left    = 0;
        forever
        begin
            @(negedge clk);
            if (stall_asked != stall_done)
            begin
                result_ready <= 1'b0;
                repeat (STALL_LONG) @(negedge clk);
                stall_done++;
            end
            if (mode_left == 0)
            begin
                mode      = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
                RX_OPEN:   result_ready <= 1'b1;
                RX_COIN:   result_ready <= ($urandom_range(0, 1) == 1);
                RX_SPARSE: result_ready <= (mode_left % 4 == 0);
                default:   result_ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (results_due.size() == 0)
            begin
                $error("result beat with nothing expected: bin_count %0d fills %0d",
                       result.bin_count, result.fills);
                fail_count++;
            end
            else
            begin
                exp_beat = results_due.pop_front();
                if (result.bin_count !== exp_beat.bin_count)
                begin
                    $error("bin_count: expected %0d, got %0d",
                           exp_beat.bin_count, result.bin_count);
                    fail_count++;
                end
                if (result.fills !== exp_beat.fills)
                begin
                    $error("fills: expected %0d, got %0d", exp_beat.fills, result.fills);
                    fail_count++;
                end
                if (result.overflow !== exp_beat.overflow)
                begin
                    $error("overflow: expected %0d, got %0d",
                           exp_beat.overflow, result.overflow);
                    fail_count++;
                end
                if (result.overflow === 1'b1)
                    overflow_beats++;
                if (result.bin_count != '0)
                    busy_reads++;
            end
        end
    end

    // Watchdog: count cycles without any handshake
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin : stimulus
        stim_row_t            rows [$];
        int                   p;
        int                   i;
        logic [CHAN_W-1:0]    s_ch;
        logic [CHAN_W-1:0]    t_ch;
        logic [WINDOW_W-1:0]  win;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        start_chan_m = '0;
        stop_chan_m  = '0;
        window_m     = '0;
        ring_head_m  = 0;
        overflow_m   = 1'b0;
        cur_time     = '0;
        for (i = 0; i < RING_DEPTH; i++)
            pend_valid_m[i] = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Under reset settings both channels are 0 and the window is 0
        rows.push_back(item_row(FUNC_READ, 0, '0, 0, 1, 0, 0, 0));
        rows.push_back(item_row(FUNC_READ, 0, '0, 32767, 1, 0, 0, 0));
        rows.push_back(item_row(FUNC_HIT, 0, '0, 0, 1, 0, 0, 0));
        // same channel for start and stop: pairs with the earlier hit only
        rows.push_back(item_row(FUNC_HIT, 0, '0, 0, 1, 0, 1, 0));
        rows.push_back(item_row(FUNC_READ, 0, '0, 0, 1, 1, 0, 0));
        rows.push_back(item_row(FUNC_HIT, 0, 48'd1, 0, 0, 0, 0, 0));
        rows.push_back(cfg_row(CFG_START_CHANNEL, 32'd3));
        rows.push_back(cfg_row(CFG_STOP_CHANNEL, 32'd4095));
        rows.push_back(cfg_row(CFG_WINDOW_NS, 32'hFFFF_FFFF));
        rows.push_back(item_row(FUNC_HIT, 3, 48'hFFFF_FFFF_FFFB, 0, 0, 0, 0, 0));
        // timestamp wraps past zero
        rows.push_back(item_row(FUNC_HIT, 4095, 48'd4, 0, 0, 0, 0, 0));
        // earlier than the pending entry: huge dt retires it
        rows.push_back(item_row(FUNC_HIT, 4095, 48'hFFFF_FFFF_FFF0, 0, 0, 0, 0, 0));
        rows.push_back(item_row(FUNC_READ, 0, '0, 9, 0, 0, 0, 0));
        rows.push_back(cfg_row(CFG_UNUSED, 32'd0));
        rows.push_back(item_row(FUNC_HIT, 3, 48'd1000, 0, 0, 0, 0, 0));
        rows.push_back(item_row(FUNC_HIT, 4095, 48'd33767, 0, 0, 0, 0, 0));
        // in the window but past the last bin
        rows.push_back(item_row(FUNC_HIT, 4095, 48'd41000, 0, 0, 0, 0, 0));
        rows.push_back(item_row(FUNC_READ, 0, '0, 32767, 0, 0, 0, 0));
        rows.push_back(item_row(FUNC_HIT, 4095, 48'hFFFF_FFFF_FFFF, 32767, 0, 0, 0, 0));

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_CFG)
            begin
                drain_results();
                write_reg(rows[i].reg_idx, rows[i].reg_data);
            end
            else
                send_beat(rows[i].beat, rows[i].typed, rows[i].want);
        end

        for (p = 0; p < PHASES; p++)
        begin
            // hold the sender until every result of the last phase is in
            drain_results();
            case (p)
                0:
                begin
                    s_ch = 12'd1;
                    t_ch = 12'd2;
                    win  = 32'd5000;
                end
                1:
                begin
                    s_ch = 12'd0;
                    t_ch = 12'd0;
                    win  = 32'd20000;
                end
                2:
                begin
                    s_ch = 12'd4095;
                    t_ch = 12'd0;
                    win  = 32'hFFFF_FFFF;
                end
                3:
                begin
                    s_ch = CHAN_W'($urandom);
                    t_ch = CHAN_W'($urandom);
                    win  = 32'd0;
                end
                4:
                begin
                    s_ch = 12'd7;
                    t_ch = 12'd7;
                    win  = 32'd300;
                end
                5:
                begin
                    s_ch = CHAN_W'($urandom);
                    t_ch = CHAN_W'($urandom);
                    win  = $urandom_range(1, 40000);
                end
                6:
                begin
                    s_ch = 12'd0;
                    t_ch = 12'd4095;
                    win  = 32'd100000;
                end
                default:
                begin
                    s_ch = CHAN_W'($urandom);
                    t_ch = CHAN_W'($urandom);
                    win  = $urandom;
                end
            endcase
            write_reg(CFG_WINDOW_NS, win);
            write_reg(CFG_STOP_CHANNEL, CFG_DATA_W'(t_ch));
            write_reg(CFG_START_CHANNEL, CFG_DATA_W'(s_ch));
            // starve the result side while beats keep coming
            if (p == 2)
                stall_asked++;
            for (i = 0; i < ITEMS_PER_PHASE; i++)
                send_beat(random_beat(), 1'b0, '0);
        end

        drain_results();
        repeat (50) @(posedge clk);
        $display("covered %0d hit beats and %0d read beats over %0d register writes",
                 hits_sent, reads_sent, settings_made);
        $display("%0d result beats carried the overflow flag, %0d reads found a nonzero bin",
                 overflow_beats, busy_reads);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
